[rtl/blifo_pkg.sv]
`default_nettype none

package blifo_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 7;

    // Operation codes carried in the request tuser
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } opcode_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_ABOVE = 3'd3,
        ST_NEG   = 3'd4
    } status_t;

    // Row-wide shift control, shared by every cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [WORD_W-1:0] word;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/bounded_lifo_stack.sv]
`default_nettype none

// LIFO stack of DEPTH signed 32-bit words built as a row of cells, cell 0
// holding the top of stack. Push, pop, peek and change requests are accepted
// whenever the output register is empty or its result is being taken, so one
// request per cycle is sustained, and the registered result appears on the
// master side in the cycle after acceptance. Push and pop shift the whole
// cell row at once. Change addresses entries from the bottom of the stack; a
// failed operation leaves the stack as it was.
module bounded_lifo_stack
#(
    parameter int DEPTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // data_in[31:0], position[38:32], zero pad
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // data_out[31:0], is_empty[32], is_full[33], pad
    output logic      [2:0]  m_tuser    // status[2:0]
);
    import blifo_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = 8;

    // request fields
    opcode_t                  opcode;
    logic signed [WORD_W-1:0] data_in;
    logic signed [POS_W-1:0]  position;

    assign opcode   = opcode_t'(s_tuser);
    assign data_in  = s_tdata[WORD_W-1:0];
    assign position = s_tdata[WORD_W+POS_W-1:WORD_W];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [WORD_W-1:0] data_out_reg;
    logic [WORD_W-1:0] data_out_next;
    logic              empty_reg;
    logic              full_reg;
    logic              accept;
    logic              is_empty_cur;
    logic              is_full_cur;
    logic [IDX_W-1:0]  pos_ext;
    logic [IDX_W-1:0]  count_ext;
    logic [IDX_W-1:0]  target_idx;
    logic              do_write;
    cell_ctrl_t        ctrl;
    logic [WORD_W-1:0] cell_q [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_empty_cur = (count_reg == '0);
    assign is_full_cur  = (count_reg == CNT_W'(DEPTH));
    assign pos_ext      = IDX_W'(unsigned'(position[POS_W-2:0]));
    assign count_ext    = IDX_W'(count_reg);
    // cell index of an absolute position: top cell is the newest entry
    assign target_idx   = count_ext - IDX_W'(1) - pos_ext;

    // operation decode and status
    always_comb
    begin
        status_next   = ST_OK;
        data_out_next = '0;
        count_next    = count_reg;
        ctrl.push     = 1'b0;
        ctrl.pop      = 1'b0;
        ctrl.word     = data_in;
        do_write      = 1'b0;
        unique case (opcode)
            OP_PUSH:
            begin
                if (is_full_cur)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctrl.push  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (is_empty_cur)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_out_next = cell_q[0];
                    if (opcode == OP_POP)
                    begin
                        ctrl.pop   = accept;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            OP_CHANGE:
            begin
                if (is_empty_cur)
                begin
                    status_next = ST_EMPTY;
                end
                else if (position[POS_W-1])
                begin
                    status_next = ST_NEG;
                end
                else if (pos_ext >= count_ext)
                begin
                    status_next = ST_ABOVE;
                end
                else
                begin
                    do_write = accept;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] upper_q;
        logic [WORD_W-1:0] lower_q;

        if (i == 0)
        begin : g_top
            assign upper_q = data_in;
        end
        else
        begin : g_mid
            assign upper_q = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign lower_q = '0;
        end
        else
        begin : g_inner
            assign lower_q = cell_q[i+1];
        end

        blifo_cell u_cell
        (
            .clk     (clk),
            .ctrl    (ctrl),
            .sel     (do_write && (target_idx == IDX_W'(i))),
            .upper_q (upper_q),
            .lower_q (lower_q),
            .q       (cell_q[i])
        );
    end

    // entry count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (s_tready)
            begin
                out_valid_reg <= s_tvalid;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            data_out_reg <= data_out_next;
            empty_reg    <= (count_next == '0);
            full_reg     <= (count_next == CNT_W'(DEPTH));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, full_reg, empty_reg, data_out_reg};

    // count stays within the row
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // a successful push grows the stack by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_PUSH && !is_full_cur)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not advance count");

    // a successful pop shrinks the stack by one
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_POP && !is_empty_cur)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not retreat count");

    // without an accepted request the count holds
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count moved without a request");

    // the result flags follow the count left behind
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (empty_reg == (count_reg == '0))
                   && (full_reg == (count_reg == CNT_W'(DEPTH))))
        else $error("result flags disagree with count");

endmodule

`default_nettype wire

[rtl/blifo_cell.sv]
`default_nettype none

module blifo_cell
(
    input  wire logic                            clk,
    input  wire blifo_pkg::cell_ctrl_t           ctrl,
    input  wire logic                            sel,
    input  wire logic [blifo_pkg::WORD_W-1:0]    upper_q,
    input  wire logic [blifo_pkg::WORD_W-1:0]    lower_q,
    output logic      [blifo_pkg::WORD_W-1:0]    q
);
    import blifo_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    // push moves entries one cell deeper, pop pulls them one cell up
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            data_next = upper_q;
        end
        else if (ctrl.pop)
        begin
            data_next = lower_q;
        end
        else if (sel)
        begin
            data_next = ctrl.word;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

[verif/stack_result_checker.sv]
`timescale 1ns / 1ps

// Watches both stream channels of the stack, keeps its own copy of the stack
// contents and predicts one result per accepted request, then compares each
// returned result with the oldest prediction.
module stack_result_checker
#(
    parameter int DEPTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // data_in[31:0], position[38:32], zero pad
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // data_out[31:0], is_empty[32], is_full[33], pad
    input  wire logic [2:0]  m_tuser,   // status[2:0]
    output int               error_count,
    output int               pending_results
);
    import blifo_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] data_out;
        logic              is_empty;
        logic              is_full;
    } stack_result_t;

    // Shadow stack: entry 0 is the oldest word
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                words_held;
    stack_result_t     expected_results [$];

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Apply one request to the shadow stack and return the result it gives
    function automatic stack_result_t apply_stack_op(input opcode_t op,
                                                      input logic [WORD_W-1:0] word,
                                                      input logic signed [POS_W-1:0] pos);
        stack_result_t r;
        int            index;
        index      = pos;
        r.status   = ST_OK;
        r.data_out = '0;
        case (op)
            OP_PUSH:
            begin
                if (words_held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[words_held] = word;
                    words_held++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (words_held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data_out = shadow_words[words_held-1];
                    if (op == OP_POP)
                    begin
                        shadow_words[words_held-1] = '0;
                        words_held--;
                    end
                end
            end
            default:
            begin
                // change: empty check first, then the position
                if (words_held == 0)
                    r.status = ST_EMPTY;
                else if (index < 0)
                    r.status = ST_NEG;
                else if (index >= words_held)
                    r.status = ST_ABOVE;
                else
                    shadow_words[index] = word;
            end
        endcase
        r.is_empty = (words_held == 0);
        r.is_full  = (words_held >= DEPTH);
        return r;
    endfunction

    initial
    begin
        error_count     = 0;
        pending_results = 0;
        words_held      = 0;
    end

    // Results are checked before new requests: a result can never belong to
    // a request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want;
        if (!rst_n)
        begin
            words_held = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.data_out)
                        report_mismatch("data_out", m_tdata[31:0], want.data_out);
                    if (m_tdata[32] !== want.is_empty)
                        report_mismatch("is_empty", 32'(m_tdata[32]), 32'(want.is_empty));
                    if (m_tdata[33] !== want.is_full)
                        report_mismatch("is_full", 32'(m_tdata[33]), 32'(want.is_full));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_stack_op(opcode_t'(s_tuser),
                                                          s_tdata[31:0], s_tdata[38:32]));
        end
        pending_results = expected_results.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

// Drives requests into the stack with varying idle and stall patterns; the
// checker beside the block does the prediction and comparison.
module testbench;
    import blifo_pkg::*;

    localparam int DEPTH          = 8;
    localparam int ITEMS_PER_PASS = 180;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    int          error_count;
    int          pending_results;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    bounded_lifo_stack #(.DEPTH(DEPTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    stack_result_checker #(.DEPTH(DEPTH)) u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one request, with a random idle gap first, and hold until taken
    task automatic send_request(input opcode_t op, input logic [WORD_W-1:0] word,
                                input logic [POS_W-1:0] pos);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos, word};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering until every outstanding result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Random request; push_pct steers the stack towards full or empty
    task automatic random_request(input int push_pct);
        opcode_t           op;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        int                roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            op = OP_PUSH;
        else
        begin
            case ($urandom_range(2))
                0:       op = OP_POP;
                1:       op = OP_PEEK;
                default: op = OP_CHANGE;
            endcase
        end
        // positions: mostly inside the depth, some anywhere, some negative
        roll = $urandom_range(9);
        if (roll < 6)
            pos = POS_W'($urandom_range(DEPTH-1));
        else if (roll < 8)
            pos = POS_W'($urandom_range(127));
        else
            pos = POS_W'($urandom_range(127, 64));
        case ($urandom_range(15))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7fff_ffff;
            2:       word = 32'h0000_0000;
            3:       word = 32'hffff_ffff;
            default: word = $urandom;
        endcase
        send_request(op, word, pos);
    endtask

    initial
    begin
        int pass;
        int push_pct;
        int n;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_PUSH;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        push_pct       = 50;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty stack errors, fill to full, change edge positions
        send_request(OP_POP,    32'h1234_5678, 7'd0);
        send_request(OP_PEEK,   32'h0,         7'd0);
        send_request(OP_CHANGE, 32'hdead_beef, 7'd0);
        send_request(OP_CHANGE, 32'hdead_beef, 7'h7f);   // empty beats negative
        send_request(OP_PUSH,   32'h8000_0000, 7'd0);
        send_request(OP_PUSH,   32'h7fff_ffff, 7'd0);
        send_request(OP_PUSH,   32'h0000_0000, 7'd0);
        send_request(OP_PUSH,   32'hffff_ffff, 7'd0);
        send_request(OP_PUSH,   32'h5555_aaaa, 7'd0);
        send_request(OP_PUSH,   32'haaaa_5555, 7'd0);
        send_request(OP_PUSH,   32'h0000_0001, 7'd0);
        send_request(OP_PUSH,   32'hfffe_0002, 7'd0);
        send_request(OP_PUSH,   32'h0bad_f00d, 7'd0);   // full
        send_request(OP_PEEK,   32'h0,         7'd0);
        send_request(OP_CHANGE, 32'h1357_9bdf, 7'd7);   // top entry
        send_request(OP_CHANGE, 32'hffff_ffff, 7'd0);   // bottom entry
        send_request(OP_CHANGE, 32'h2468_ace0, 7'd8);   // above top
        send_request(OP_CHANGE, 32'h2468_ace0, 7'd63);
        send_request(OP_CHANGE, 32'h2468_ace0, 7'h40);  // most negative
        send_request(OP_CHANGE, 32'h2468_ace0, 7'h7f);  // minus one
        send_request(OP_POP,    32'h0,         7'd0);
        send_request(OP_PEEK,   32'h0,         7'd0);
        drain_results();

        // Random passes under different idle and stall patterns
        for (pass = 0; pass < 4; pass++)
        begin
            case (pass)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (n = 0; n < ITEMS_PER_PASS; n++)
            begin
                if (n % 30 == 0)
                begin
                    case ($urandom_range(2))
                        0:       push_pct = 75;
                        1:       push_pct = 25;
                        default: push_pct = 50;
                    endcase
                end
                random_request(push_pct);
            end
            drain_results();
        end

        repeat (5) @(posedge clk);
        if (error_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/blifo_pkg.sv
rtl/blifo_cell.sv
rtl/bounded_lifo_stack.sv
verif/stack_result_checker.sv
verif/testbench.sv
